/* rtl/rtc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_pkg: shared types and constants for the timestamp checker
// Character class word passed from the front classifier to the back parser,
// length limits of the timestamp format, and default queue depths.
// ----------------------------------------------------------------------------
package rtc_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned POS_W     = 6;
  localparam int unsigned ZONE_W    = 3;

  localparam int unsigned MIN_LEN   = 20;
  localparam int unsigned LEN_LIMIT = 32;
  localparam int unsigned FIXED_LEN = 19;
  localparam int unsigned ZONE_DONE = 6;
  localparam int unsigned ZONE_COLON = 3;

  localparam int unsigned TOK_DEPTH_DEF = 4;
  localparam int unsigned RES_DEPTH_DEF = 2;

  // One classified character. At most one class bit is set, except that
  // '-' is both a dash and a sign.
  typedef struct packed {
    logic digit;
    logic dash;
    logic tee;
    logic colon;
    logic dot;
    logic zulu;
    logic sign;
    logic last;
  } tok_t;

endpackage

/* rtl/rfc3339_timestamp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfc3339_timestamp_checker: streaming RFC 3339 date-time validator
// Checks a timestamp string fed one byte per word and returns one verdict
// word per string.
// ----------------------------------------------------------------------------
// The block takes one character per clock while in_full is low: the parser
// retires one character every cycle while the character queue holds one, and
// only the character that ends a string also needs a free slot in the result
// queue. A classified character lands in the character queue when accepted,
// the parser judges it once it reaches the head of that queue, and the
// verdict then lands in the result queue and shows on the result ports.
// Both sides are queues: in_full rises only when the character queue
// (TOK_DEPTH words) backs up behind a blocked result queue (RES_DEPTH
// verdicts), so a slow consumer stalls the input without losing anything.
// After each verdict the parser is back in its start state.
// ----------------------------------------------------------------------------
module rfc3339_timestamp_checker #(
  parameter int unsigned TOK_DEPTH = rtc_pkg::TOK_DEPTH_DEF,
  parameter int unsigned RES_DEPTH = rtc_pkg::RES_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // character side
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [rtc_pkg::CHAR_W-1:0] in_char_code,
  input  logic                       in_is_last,
  // verdict side
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic                       out_is_valid
);

  rtc_pkg::tok_t front_tok;
  rtc_pkg::tok_t back_tok;
  logic          front_push;
  logic          tok_empty;
  logic          tok_take;
  logic          res_full;
  logic          res_push;
  logic          res_valid;

  // Front: classify the byte as it arrives.
  rtc_front u_front (
    .in_push      (in_push),
    .in_char_code (in_char_code),
    .in_is_last   (in_is_last),
    .q_full       (in_full),
    .q_push       (front_push),
    .q_tok        (front_tok)
  );

  // Decoupling queue between classifier and parser.
  rtc_fifo #(
    .WIDTH ($bits(rtc_pkg::tok_t)),
    .DEPTH (TOK_DEPTH)
  ) u_tok_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (front_push),
    .wdata (front_tok),
    .full  (in_full),
    .pop   (tok_take),
    .rdata (back_tok),
    .empty (tok_empty)
  );

  // Back: format state machine, one character per cycle while characters are queued and the result queue has room.
  rtc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok       (back_tok),
    .tok_avail (!tok_empty),
    .tok_take  (tok_take),
    .res_room  (!res_full),
    .res_push  (res_push),
    .res_valid (res_valid)
  );

  // Result queue: verdicts wait here until popped.
  rtc_fifo #(
    .WIDTH (1),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_valid),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_is_valid),
    .empty (out_empty)
  );

endmodule

/* rtl/rtc_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_fifo: small register queue
// Flop-based first-in first-out queue, head word shown while not empty.
// Push while full and pop while empty are ignored.
// ----------------------------------------------------------------------------
module rtc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

/* rtl/rtc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_front: character classifier
// Turns an incoming byte into a class word for the parser queue.
// ----------------------------------------------------------------------------
module rtc_front (
  input  logic                       in_push,
  input  logic [rtc_pkg::CHAR_W-1:0] in_char_code,
  input  logic                       in_is_last,
  input  logic                       q_full,
  output logic                       q_push,
  output rtc_pkg::tok_t              q_tok
);

  localparam logic [rtc_pkg::CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [rtc_pkg::CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [rtc_pkg::CHAR_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [rtc_pkg::CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [rtc_pkg::CHAR_W-1:0] CH_T     = 8'h54;
  localparam logic [rtc_pkg::CHAR_W-1:0] CH_Z     = 8'h5A;
  localparam logic [rtc_pkg::CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [rtc_pkg::CHAR_W-1:0] CH_DOT   = 8'h2E;

  assign q_push = in_push && !q_full;

  always_comb begin
    q_tok       = '0;
    q_tok.digit = (in_char_code >= CH_0) && (in_char_code <= CH_9);
    q_tok.dash  = (in_char_code == CH_DASH);
    q_tok.tee   = (in_char_code == CH_T);
    q_tok.colon = (in_char_code == CH_COLON);
    q_tok.dot   = (in_char_code == CH_DOT);
    q_tok.zulu  = (in_char_code == CH_Z);
    q_tok.sign  = (in_char_code == CH_PLUS) || (in_char_code == CH_DASH);
    q_tok.last  = in_is_last;
  end

endmodule

/* rtl/rtc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_back: timestamp parser
// Walks the classified characters through the format phases and produces
// one verdict per string, on its last character.
// ----------------------------------------------------------------------------
module rtc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  rtc_pkg::tok_t tok,
  input  logic          tok_avail,
  output logic          tok_take,
  input  logic          res_room,
  output logic          res_push,
  output logic          res_valid
);

  typedef enum logic [2:0] {
    PH_FIXED  = 3'd0,
    PH_DOT    = 3'd1,
    PH_FRAC   = 3'd2,
    PH_ZULU   = 3'd3,
    PH_OFFSET = 3'd4
  } phase_t;

  localparam logic [rtc_pkg::POS_W-1:0] POS_DASH1  = 6'd4;
  localparam logic [rtc_pkg::POS_W-1:0] POS_DASH2  = 6'd7;
  localparam logic [rtc_pkg::POS_W-1:0] POS_TEE    = 6'd10;
  localparam logic [rtc_pkg::POS_W-1:0] POS_COLON1 = 6'd13;
  localparam logic [rtc_pkg::POS_W-1:0] POS_COLON2 = 6'd16;

  phase_t                        phase_r, phase_nxt;
  logic [rtc_pkg::POS_W-1:0]     pos_r, pos_nxt;
  logic [rtc_pkg::ZONE_W-1:0]    zone_r, zone_nxt;
  logic                          ok_r, ok_nxt;
  logic                          fixed_ok;

  // A string's last character needs room for its verdict.
  assign tok_take = tok_avail && (!tok.last || res_room);
  assign res_push = tok_take && tok.last;

  always_comb begin
    case (pos_r) inside
      POS_DASH1, POS_DASH2:   fixed_ok = tok.dash;
      POS_TEE:                fixed_ok = tok.tee;
      POS_COLON1, POS_COLON2: fixed_ok = tok.colon;
      default:                fixed_ok = tok.digit;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    zone_nxt  = zone_r;
    ok_nxt    = ok_r;
    if (ok_r) begin
      case (phase_r)
        PH_FIXED: begin
          if (pos_r < rtc_pkg::POS_W'(rtc_pkg::FIXED_LEN)) begin
            if (!fixed_ok) ok_nxt = 1'b0;
          end else if (tok.dot) begin
            phase_nxt = PH_DOT;
          end else if (tok.zulu) begin
            phase_nxt = PH_ZULU;
          end else if (tok.sign) begin
            phase_nxt = PH_OFFSET;
            zone_nxt  = rtc_pkg::ZONE_W'(1);
          end else begin
            ok_nxt = 1'b0;
          end
        end
        PH_DOT: begin
          if (tok.digit) phase_nxt = PH_FRAC;
          else ok_nxt = 1'b0;
        end
        PH_FRAC: begin
          if (!tok.digit) begin
            if (tok.zulu) begin
              phase_nxt = PH_ZULU;
            end else if (tok.sign) begin
              phase_nxt = PH_OFFSET;
              zone_nxt  = rtc_pkg::ZONE_W'(1);
            end else begin
              ok_nxt = 1'b0;
            end
          end
        end
        PH_OFFSET: begin
          if (zone_r >= rtc_pkg::ZONE_W'(rtc_pkg::ZONE_DONE)) begin
            ok_nxt = 1'b0;
          end else if ((zone_r == rtc_pkg::ZONE_W'(rtc_pkg::ZONE_COLON)) ?
                       tok.colon : tok.digit) begin
            zone_nxt = zone_r + 1'b1;
          end else begin
            ok_nxt = 1'b0;
          end
        end
        default: ok_nxt = 1'b0;   // nothing may follow 'Z'
      endcase
    end
    pos_nxt = (pos_r < rtc_pkg::POS_W'(rtc_pkg::LEN_LIMIT)) ? pos_r + 1'b1 : pos_r;
  end

  assign res_valid = ok_nxt
                  && (pos_nxt >= rtc_pkg::POS_W'(rtc_pkg::MIN_LEN))
                  && (pos_nxt <  rtc_pkg::POS_W'(rtc_pkg::LEN_LIMIT))
                  && ((phase_nxt == PH_ZULU)
                      || ((phase_nxt == PH_OFFSET)
                          && (zone_nxt == rtc_pkg::ZONE_W'(rtc_pkg::ZONE_DONE))));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIXED;
      pos_r   <= '0;
      zone_r  <= '0;
      ok_r    <= 1'b1;
    end else if (tok_take) begin
      if (tok.last) begin
        phase_r <= PH_FIXED;
        pos_r   <= '0;
        zone_r  <= '0;
        ok_r    <= 1'b1;
      end else begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        zone_r  <= zone_nxt;
        ok_r    <= ok_nxt;
      end
    end
  end

endmodule

/* rtl/rtc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_checker: port-level assertions for the timestamp checker
// Watches the top-level ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module rtc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_push,
  input logic in_full,
  input logic out_empty,
  input logic out_pop,
  input logic out_is_valid
);

  localparam int unsigned CNT_W = $clog2(rtc_pkg::MIN_LEN + 1);

  // Characters accepted since reset, saturating at the minimum length.
  logic [CNT_W-1:0] acc_cnt_r;
  logic             in_acc;

  assign in_acc = in_push && !in_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_cnt_r <= '0;
    end else if (in_acc && (acc_cnt_r < CNT_W'(rtc_pkg::MIN_LEN))) begin
      acc_cnt_r <= acc_cnt_r + 1'b1;
    end
  end

  // Reset leaves the result queue empty and the character queue not full.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  // A positive verdict needs at least the minimum length of characters accepted since reset.
  a_valid_needs_len: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_is_valid) |-> (acc_cnt_r == CNT_W'(rtc_pkg::MIN_LEN)))
    else $error("valid verdict before enough characters");

  // No verdict can appear without a character accepted before it.
  a_no_early_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (acc_cnt_r != '0))
    else $error("verdict with no characters accepted");

  // A waiting verdict holds until it is popped.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_is_valid)))
    else $error("waiting verdict changed or vanished");

endmodule

bind rfc3339_timestamp_checker rtc_checker u_rtc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_push      (in_push),
  .in_full      (in_full),
  .out_empty    (out_empty),
  .out_pop      (out_pop),
  .out_is_valid (out_is_valid)
);
